// ----- hw/rtl/lfu_pkg.sv -----
// Shared types and constants for the LFU replacement cache.
package lfu_pkg;
	localparam int unsigned CAPACITY_DEFAULT = 16;
	localparam int unsigned KEY_W   = 32;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned STAMP_W = 32;
	localparam int unsigned CAP_W   = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_OUT
	} lfu_state_t;

	typedef struct packed {
		logic               action;
		logic [KEY_W-1:0]   key;
		logic [DATA_W-1:0]  value;
	} lfu_req_t;

	typedef struct packed {
		logic               found;
		logic [DATA_W-1:0]  read_value;
		logic               evicted;
	} lfu_rsp_t;

	// one memory word per slot (valid kept in flops)
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [DATA_W-1:0]  data;
		logic [COUNT_W-1:0] count;
		logic [STAMP_W-1:0] stamp;
	} lfu_entry_t;
endpackage

// ----- hw/rtl/lfu_if.sv -----
// Valid/ready channel interfaces for requests and responses.
interface lfu_req_if import lfu_pkg::*; ();
	logic     valid;
	logic     ready;
	lfu_req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface lfu_rsp_if import lfu_pkg::*; ();
	logic     valid;
	logic     ready;
	lfu_rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/lfu_replacement_cache.sv -----
// LFU cache with LRU tie break: top level.
// One transaction at a time: a new request is taken only once the previous response
// has been accepted, and each one waits on the serial scan of the single read port of
// the slot memory.
// Reset: all slots invalid, access clock zero, capacity_in_use 16; slot
// memory contents stay undefined, masked by the valid flops.
module lfu_replacement_cache import lfu_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEFAULT,
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	lfu_req_if.sink          req,
	lfu_rsp_if.source        rsp
);
	logic [CAP_W-1:0] capacity_q;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	lfu_entry_t       mem_wdata, mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	lfu_ctrl #(.DEPTH(CAPACITY)) u_ctrl (
		.clk, .arst_n,
		.capacity_in_use(capacity_q),
		.req, .rsp,
		.mem_we, .mem_waddr, .mem_wdata, .mem_raddr, .mem_rdata
	);

	lfu_slot_mem #(.DEPTH(CAPACITY)) u_mem (
		.clk,
		.we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);
endmodule

// ----- hw/rtl/lfu_slot_mem.sv -----
// Slot memory: one write port, one read port, registered read data.
module lfu_slot_mem import lfu_pkg::*; #(
	parameter int unsigned DEPTH = CAPACITY_DEFAULT,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  lfu_entry_t       wdata,
	input  logic [AW-1:0]    raddr,
	output lfu_entry_t       rdata
);
	lfu_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/lfu_ctrl.sv -----
// Sequencer: scans all slots for hit, free slot and victim, then writes back.
module lfu_ctrl import lfu_pkg::*; #(
	parameter int unsigned DEPTH = CAPACITY_DEFAULT,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned NW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CAP_W-1:0] capacity_in_use,
	lfu_req_if.sink          req,
	lfu_rsp_if.source        rsp,
	output logic             mem_we,
	output logic [AW-1:0]    mem_waddr,
	output lfu_entry_t       mem_wdata,
	output logic [AW-1:0]    mem_raddr,
	input  lfu_entry_t       mem_rdata
);
	lfu_state_t state_q, state_d;
	lfu_req_t   req_q;
	logic [DEPTH-1:0] valid_q;
	logic [NW-1:0] rd_idx_q;    // next address to read
	logic [AW-1:0] cmp_idx_q;   // slot whose data arrives this cycle
	logic          cmp_vld_q;
	logic          hit_q, free_q, vic_q;
	logic [AW-1:0] hit_idx_q, free_idx_q, vic_idx_q;
	lfu_entry_t    hit_ent_q;
	logic [COUNT_W-1:0] vic_cnt_q;
	logic [STAMP_W-1:0] vic_stamp_q;
	logic [NW-1:0] occ_q;
	logic [STAMP_W-1:0] clock_q;
	lfu_rsp_t      rsp_q;

	logic [NW:0]   cap_eff;
	logic          scan_done;
	logic          cur_valid, better;
	logic          wr_en, wr_new, wr_evict;
	logic [AW-1:0] wr_idx;
	logic [COUNT_W-1:0] base_cnt;

	assign cap_eff = (32'(capacity_in_use) < DEPTH) ?
		(NW+1)'(capacity_in_use) : (NW+1)'(DEPTH);
	assign scan_done = cmp_vld_q && (32'(cmp_idx_q) == DEPTH - 1);
	assign cur_valid = valid_q[cmp_idx_q];
	assign better = !vic_q || (mem_rdata.count < vic_cnt_q) ||
		(mem_rdata.count == vic_cnt_q && mem_rdata.stamp < vic_stamp_q);

	// decide the write-back once the scan is complete
	always_comb begin
		wr_en    = 1'b0;
		wr_new   = 1'b0;
		wr_evict = 1'b0;
		wr_idx   = hit_idx_q;
		if (req_q.action == ACT_GET) begin
			wr_en = hit_q;
		end else if (cap_eff != '0) begin
			wr_en = 1'b1;
			if (!hit_q) begin
				wr_new = 1'b1;
				if ((NW+1)'(occ_q) >= cap_eff && vic_q) begin
					wr_idx = vic_idx_q;
					wr_evict = 1'b1;
				end else if (free_q) begin
					wr_idx = free_idx_q;
				end else begin
					wr_idx = vic_idx_q;
					wr_evict = 1'b1;
				end
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (req.valid) state_d = ST_SCAN;
			ST_SCAN:  if (scan_done) state_d = ST_WRITE;
			ST_WRITE: state_d = ST_OUT;
			ST_OUT:   if (rsp.ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	assign base_cnt = wr_new ? '0 : hit_ent_q.count;

	always_comb begin
		req.ready = (state_q == ST_IDLE);
		rsp.valid = (state_q == ST_OUT);
		rsp.payload = rsp_q;
		mem_raddr = rd_idx_q[AW-1:0];
		mem_we    = (state_q == ST_WRITE) && wr_en;
		mem_waddr = wr_idx;
		mem_wdata.key   = req_q.key;
		mem_wdata.data  = (req_q.action == ACT_PUT) ? req_q.value : hit_ent_q.data;
		mem_wdata.count = (base_cnt == COUNT_MAX) ? base_cnt : base_cnt + 1'b1;
		mem_wdata.stamp = clock_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			clock_q   <= '0;
			rd_idx_q  <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					rd_idx_q  <= '0;
					cmp_vld_q <= 1'b0;
					if (req.valid) begin
						rd_idx_q <= NW'(1);
						cmp_vld_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (rd_idx_q < NW'(DEPTH)) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (scan_done) begin
						cmp_vld_q <= 1'b0;
					end
				end
				ST_WRITE: begin
					// point the read port back at slot 0 for the next request
					rd_idx_q <= '0;
					if (wr_en) begin
						clock_q <= clock_q + 1'b1;
						valid_q[wr_idx] <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// scan datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			req_q     <= req.payload;
			cmp_idx_q <= '0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			vic_q     <= 1'b0;
			occ_q     <= '0;
		end else if (state_q == ST_SCAN && cmp_vld_q) begin
			cmp_idx_q <= cmp_idx_q + 1'b1;
			if (!cur_valid) begin
				if (!free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= cmp_idx_q;
				end
			end else begin
				occ_q <= occ_q + 1'b1;
				if (!hit_q && mem_rdata.key == req_q.key) begin
					hit_q     <= 1'b1;
					hit_idx_q <= cmp_idx_q;
					hit_ent_q <= mem_rdata;
				end
				if (better) begin
					vic_q       <= 1'b1;
					vic_idx_q   <= cmp_idx_q;
					vic_cnt_q   <= mem_rdata.count;
					vic_stamp_q <= mem_rdata.stamp;
				end
			end
		end
		if (state_q == ST_WRITE) begin
			rsp_q.found      <= hit_q && (req_q.action == ACT_GET || cap_eff != '0);
			rsp_q.read_value <= (hit_q && req_q.action == ACT_GET) ? hit_ent_q.data : '0;
			rsp_q.evicted    <= wr_evict;
		end
	end
endmodule

// ----- test/lfu_replacement_cache_tb.sv -----
// Self-checking testbench for the LFU replacement cache with LRU tie break.
module lfu_replacement_cache_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lfu_pkg::*;

	localparam int unsigned NSLOT = 16;
	localparam int unsigned LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;

	lfu_req_if req_ch ();
	lfu_rsp_if rsp_ch ();

	lfu_replacement_cache #(.CAPACITY(NSLOT)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req_ch.sink), .rsp(rsp_ch.source)
	);

	always #2 clk = ~clk;

	// predictor state
	logic               mdl_valid [NSLOT];
	logic [KEY_W-1:0]   mdl_key [NSLOT];
	logic [DATA_W-1:0]  mdl_data [NSLOT];
	logic [COUNT_W-1:0] mdl_count [NSLOT];
	logic [STAMP_W-1:0] mdl_stamp [NSLOT];
	logic [STAMP_W-1:0] mdl_clock;
	logic [CAP_W-1:0]   mdl_cap;

	lfu_req_t pending_reqs [$];
	lfu_rsp_t expected_rsps [$];
	int errors = 0;
	int n_rsp = 0, n_hit = 0, n_evict = 0;
	int unsigned cycle = 0;
	bit in_stall_burst = 1'b0;
	bit quiet = 1'b0;
	bit hold_rsp = 1'b0;
	bit req_acc_q = 1'b0;

	function automatic void touch_slot(input int s);
		if (mdl_count[s] != COUNT_MAX)
			mdl_count[s] = mdl_count[s] + 1'b1;
		mdl_stamp[s] = mdl_clock;
		mdl_clock = mdl_clock + 1'b1;
	endfunction

	function automatic lfu_rsp_t predict_lookup(input lfu_req_t r);
		lfu_rsp_t o;
		int hit, free_s, victim, occupied, cap, s;
		o = '0;
		hit = -1; free_s = -1; victim = -1; occupied = 0;
		cap = (mdl_cap < NSLOT) ? int'(mdl_cap) : NSLOT;
		for (int i = 0; i < NSLOT; i++) begin
			if (!mdl_valid[i]) begin
				if (free_s < 0) free_s = i;
				continue;
			end
			occupied++;
			if (hit < 0 && mdl_key[i] == r.key) hit = i;
			if (victim < 0 || mdl_count[i] < mdl_count[victim] ||
			    (mdl_count[i] == mdl_count[victim] && mdl_stamp[i] < mdl_stamp[victim]))
				victim = i;
		end
		if (r.action == ACT_GET) begin
			if (hit >= 0) begin
				touch_slot(hit);
				o.found = 1'b1;
				o.read_value = mdl_data[hit];
			end
			return o;
		end
		if (cap == 0) return o;
		if (hit >= 0) begin
			mdl_data[hit] = r.value;
			touch_slot(hit);
			o.found = 1'b1;
			return o;
		end
		if ((occupied >= cap && victim >= 0) || free_s < 0) begin
			s = victim;
			o.evicted = 1'b1;
		end else begin
			s = free_s;
		end
		mdl_valid[s] = 1'b1;
		mdl_key[s] = r.key;
		mdl_data[s] = r.value;
		mdl_count[s] = '0;
		touch_slot(s);
		return o;
	endfunction

	// driver: req_acc_q tells whether the previous rising edge took the transaction
	always @(negedge clk) begin
		if (req_acc_q)
			void'(pending_reqs.pop_front());
		if (!arst_n || pending_reqs.size() == 0) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_acc_q) begin
			req_ch.valid <= quiet || ($urandom_range(99) >= 17);
			req_ch.payload <= pending_reqs[0];
		end
	end

	always @(negedge clk) begin
		if (hold_rsp)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= quiet || ($urandom_range(99) >= 17);
	end

	// monitor
	always @(posedge clk) begin
		cycle <= cycle + 1;
		req_acc_q <= req_ch.valid && req_ch.ready;
		if (req_ch.valid && req_ch.ready)
			expected_rsps.push_back(predict_lookup(req_ch.payload));
		if (rsp_ch.valid && rsp_ch.ready) begin
			n_rsp++;
			if (expected_rsps.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected response %p", rsp_ch.payload);
			end else begin
				lfu_rsp_t e;
				e = expected_rsps.pop_front();
				if (e.found) n_hit++;
				if (e.evicted) n_evict++;
				if (e.found !== rsp_ch.payload.found ||
				    e.read_value !== rsp_ch.payload.read_value ||
				    e.evicted !== rsp_ch.payload.evicted) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp found=%0b val=%h ev=%0b got found=%0b val=%h ev=%0b",
						         e.found, e.read_value, e.evicted, rsp_ch.payload.found,
						         rsp_ch.payload.read_value, rsp_ch.payload.evicted);
				end
			end
		end
		if (cycle >= LIMIT) begin
			$display("timeout at cycle %0d", cycle);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic add_req(input logic act, input logic [31:0] k, input logic [31:0] v);
		lfu_req_t r;
		r.action = act; r.key = k; r.value = v;
		pending_reqs.push_back(r);
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] c);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(negedge clk);
		cfg_we <= 1'b0;
		mdl_cap = c;
	endtask

	// mostly a small key pool so hits and evictions are common
	task automatic random_phase(input int n);
		logic [31:0] k;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) < 8) k = $urandom_range(24);
			else k = $urandom;
			add_req(1'($urandom_range(1)), k, $urandom);
		end
	endtask

	initial begin
		logic [CAP_W-1:0] caps [6] = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd3, 5'd16};
		for (int i = 0; i < NSLOT; i++) begin
			mdl_valid[i] = 1'b0; mdl_key[i] = '0; mdl_data[i] = '0;
			mdl_count[i] = '0; mdl_stamp[i] = '0;
		end
		mdl_clock = '0;
		mdl_cap = CAP_RESET;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		rsp_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, miss, hit, update, fill and evict, tie break
		add_req(ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		add_req(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		add_req(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		add_req(ACT_PUT, 32'hFFFF_FFFF, 32'h0);
		add_req(ACT_GET, 32'h8000_0000, 32'h0);
		add_req(ACT_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		add_req(ACT_GET, 32'h7FFF_FFFF, 32'h1234_5678);
		for (int i = 0; i < 15; i++) add_req(ACT_PUT, 100 + i, i);
		add_req(ACT_GET, 32'hFFFF_FFFF, 32'h0);
		add_req(ACT_GET, 32'h0, 32'h0);
		drain();

		// long back-pressure stretch while the sender keeps offering
		random_phase(40);
		hold_rsp = 1'b1;
		repeat (300) @(posedge clk);
		hold_rsp = 1'b0;
		drain();

		// hammer one key to build up a high use count
		quiet = 1'b1;
		for (int i = 0; i < 300; i++) add_req(ACT_GET, 32'h7FFF_FFFF, 32'h0);
		drain();
		quiet = 1'b0;

		foreach (caps[c]) begin
			write_capacity(caps[c]);
			if (c == 2) quiet = 1'b1;
			random_phase(260);
			drain();
			quiet = 1'b0;
		end

		$display("covered %0d responses: %0d hits, %0d evictions", n_rsp, n_hit, n_evict);
		$display("capacity settings 16, 0, 1, 31, 3, 16 with long backpressure and a hot key");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
